FILE: rtl/snc_pkg.sv
package snc_pkg;

	// Default limit on the number of bytes in one name.
	localparam int DEF_MAX_NAME_BYTES = 64;

	localparam int MAIN_CHARS = 8;
	localparam int EXT_CHARS  = 3;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_DOT     = 8'h2E;
	localparam logic [7:0] CHAR_DELETED = 8'hE5;
	localparam logic [7:0] CHAR_KANJI   = 8'h05;

	localparam logic [MAIN_CHARS*8-1:0] SPACES_MAIN = {MAIN_CHARS{CHAR_SPACE}};
	localparam logic [EXT_CHARS*8-1:0]  SPACES_EXT  = {EXT_CHARS{CHAR_SPACE}};

	// Where the parser stands within the name.
	typedef enum logic [3:0] {
		PH_MAIN      = 4'b0001,
		PH_DOTS_MAIN = 4'b0010,
		PH_EXT       = 4'b0100,
		PH_DOTS_EXT  = 4'b1000
	} phase_t;

	// Bytes that may never appear in a short name.
	function automatic logic is_forbidden(input logic [7:0] b);
		logic hit;
		begin
			case (b) inside
				8'h00, 8'h22, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B,
				8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h5B, 8'h5C, 8'h5D, 8'h7C: hit = 1'b1;
				default: hit = 1'b0;
			endcase
			return hit;
		end
	endfunction

	// Upper-cases a to z only; every other byte passes unchanged.
	function automatic logic [7:0] upper_of(input logic [7:0] b);
		logic [7:0] c;
		begin
			if (b >= 8'h61 && b <= 8'h7A) begin
				c = b - 8'h20;
			end else begin
				c = b;
			end
			return c;
		end
	endfunction

endpackage

FILE: rtl/short_name_converter_top.sv
// m_tvalid rises once the last byte has moved from the input register into the result register.
// Throughput: one name byte per cycle; a last byte waits in the input register only while the
// result register is full and m_tready is low.
// Reset: arst_n clears the control state asynchronously; the parser returns to the start of a name
// with space-filled buffers and no error, and both the input and result registers are empty.
module short_name_converter_top #(
	parameter int MAX_NAME_BYTES = snc_pkg::DEF_MAX_NAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream, one name byte per transaction.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] name_byte
	input  logic        s_tlast,   // last_byte
	// Result stream, one transaction per name.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [63:0] main_part, [87:64] extension_part
	output logic        m_tuser    // [0] invalid
);
	import snc_pkg::*;

	// Byte counter wide enough to hold the limit itself.
	localparam int CNT_W = $clog2(MAX_NAME_BYTES + 1);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state.
	phase_t                     phase_q;
	logic [CNT_W-1:0]           count_q;
	logic [3:0]                 main_len_q;
	logic [2:0]                 ext_len_q;
	logic [MAIN_CHARS*8-1:0]    main_buf_q;
	logic [EXT_CHARS*8-1:0]     ext_buf_q;
	logic                       error_q;

	// Result register.
	logic                       out_valid_q;
	logic [MAIN_CHARS*8-1:0]    out_main_q;
	logic [EXT_CHARS*8-1:0]     out_ext_q;
	logic                       out_invalid_q;

	// Next parser state for the byte in the input register.
	phase_t                     phase_n;
	logic [CNT_W-1:0]           count_n;
	logic [3:0]                 main_len_n;
	logic [2:0]                 ext_len_n;
	logic [MAIN_CHARS*8-1:0]    main_buf_n;
	logic [EXT_CHARS*8-1:0]     ext_buf_n;
	logic                       error_n;

	logic s1_fire;
	logic s_fire;

	// A byte that does not end a name never needs the result register, so it always moves on.
	// The last byte moves on once the result register is free or is being emptied.
	assign s1_fire  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_fire;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// One byte of parsing: length and character checks, separator tracking, buffer write.
	always_comb begin
		logic [7:0] c;
		phase_t     ph;
		phase_n    = phase_q;
		count_n    = count_q;
		main_len_n = main_len_q;
		ext_len_n  = ext_len_q;
		main_buf_n = main_buf_q;
		ext_buf_n  = ext_buf_q;
		error_n    = error_q;
		c          = upper_of(byte_s1);
		ph         = phase_q;

		if (count_q >= CNT_W'(MAX_NAME_BYTES)) begin
			error_n = 1'b1;
		end else begin
			if (count_q == '0) begin
				// The first byte may not mark a deleted entry, start with a dot, or be a
				// control code or space, except for the escaped lead byte.
				if (byte_s1 != CHAR_KANJI && (byte_s1 == CHAR_DELETED ||
						byte_s1 == CHAR_DOT || byte_s1 <= CHAR_SPACE)) begin
					error_n = 1'b1;
				end
			end else if (byte_s1 < CHAR_SPACE) begin
				error_n = 1'b1;
			end
			count_n = count_q + CNT_W'(1);
		end

		if (is_forbidden(byte_s1)) begin
			error_n = 1'b1;
		end

		if (byte_s1 == CHAR_DOT) begin
			// A run of dots counts as a single separator.
			case (phase_q)
				PH_MAIN: phase_n = PH_DOTS_MAIN;
				PH_EXT:  phase_n = PH_DOTS_EXT;
				default: phase_n = phase_q;
			endcase
		end else begin
			if (phase_q == PH_DOTS_MAIN) begin
				ph = PH_EXT;
			end
			phase_n = ph;
			case (ph)
				PH_DOTS_EXT: begin
					// Text after the extension's dots is a third part.
					error_n = 1'b1;
				end
				PH_MAIN: begin
					if (main_len_q < 4'd8) begin
						for (int i = 0; i < MAIN_CHARS; i++) begin
							if (main_len_q == 4'(i)) begin
								main_buf_n[(MAIN_CHARS-1-i)*8 +: 8] = c;
							end
						end
						main_len_n = main_len_q + 4'd1;
					end else begin
						main_len_n = 4'd9;
						error_n    = 1'b1;
					end
				end
				default: begin
					if (ext_len_q < 3'd3) begin
						for (int i = 0; i < EXT_CHARS; i++) begin
							if (ext_len_q == 3'(i)) begin
								ext_buf_n[(EXT_CHARS-1-i)*8 +: 8] = c;
							end
						end
						ext_len_n = ext_len_q + 3'd1;
					end else begin
						ext_len_n = 3'd4;
						error_n   = 1'b1;
					end
				end
			endcase
		end
	end

	// The parser starts over after every last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAIN;
			count_q    <= '0;
			main_len_q <= '0;
			ext_len_q  <= '0;
			main_buf_q <= SPACES_MAIN;
			ext_buf_q  <= SPACES_EXT;
			error_q    <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				phase_q    <= PH_MAIN;
				count_q    <= '0;
				main_len_q <= '0;
				ext_len_q  <= '0;
				main_buf_q <= SPACES_MAIN;
				ext_buf_q  <= SPACES_EXT;
				error_q    <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				count_q    <= count_n;
				main_len_q <= main_len_n;
				ext_len_q  <= ext_len_n;
				main_buf_q <= main_buf_n;
				ext_buf_q  <= ext_buf_n;
				error_q    <= error_n;
			end
		end
	end

	// Result register; a rejected name reports zero characters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_main_q    <= error_n ? '0 : main_buf_n;
			out_ext_q     <= error_n ? '0 : ext_buf_n;
			out_invalid_q <= error_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ext_q, out_main_q};
	assign m_tuser  = out_invalid_q;

endmodule
